/* hdl/cddu_pkg.sv */
package cddu_pkg;

  localparam int unsigned DefNumDisplays      = 4;
  localparam int unsigned DefDigitsPerDisplay = 8;
  localparam int unsigned MaxDigits           = 8;
  localparam int unsigned CodeW               = 8;
  localparam int unsigned DigitRegW           = 4;
  localparam int unsigned FrameSlotW          = 2;
  localparam int unsigned InQueueDepth        = 2;
  localparam int unsigned OutQueueDepth       = 4;

  localparam logic [CodeW-1:0]     BlankCode   = 8'h0f;
  localparam logic [DigitRegW-1:0] TopRegister = 4'd8;

  // One command toward the chained drivers.
  typedef struct packed {
    logic [FrameSlotW-1:0] frame_slot;
    logic [DigitRegW-1:0]  digit_register;
    logic [CodeW-1:0]      segment_code;
    logic                  last;
  } cmd_t;

endpackage

/* hdl/cddu_ram.sv */
module cddu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cddu_front.sv */
module cddu_front #(
  parameter int unsigned NumDisplays      = cddu_pkg::DefNumDisplays,
  parameter int unsigned DigitsPerDisplay = cddu_pkg::DefDigitsPerDisplay,
  localparam int unsigned SlotW = (NumDisplays > 1) ? $clog2(NumDisplays) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic [1:0] display_index_i,
  input  logic [cddu_pkg::MaxDigits-1:0][cddu_pkg::CodeW-1:0] digit_codes_i,
  output logic q_valid_o,
  input  logic q_take_i,
  output logic [SlotW-1:0] q_slot_o,
  output logic [DigitsPerDisplay-1:0][cddu_pkg::CodeW-1:0] q_codes_o
);

  localparam int unsigned Depth = cddu_pkg::InQueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [SlotW-1:0] slot_q [Depth];
  logic [DigitsPerDisplay-1:0][cddu_pkg::CodeW-1:0] codes_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  logic accept, in_range, enq, deq;
  logic [SlotW-1:0] slot_new;

  // An index past the end of the chain is taken and dropped.
  assign accept   = push && !full;
  assign in_range = 32'(display_index_i) < NumDisplays;
  assign slot_new = SlotW'(NumDisplays - 1) - SlotW'(display_index_i);
  assign enq      = accept && in_range;
  assign deq      = q_take_i && q_valid_o;

  assign full      = count_q == CntW'(Depth);
  assign q_valid_o = count_q != '0;
  assign q_slot_o  = slot_q[rd_ptr_q];
  assign q_codes_o = codes_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(enq) - CntW'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_ptr_q]  <= slot_new;
      codes_q[wr_ptr_q] <= digit_codes_i[DigitsPerDisplay-1:0];
    end
  end

endmodule

/* hdl/cddu_back.sv */
module cddu_back #(
  parameter int unsigned NumDisplays      = cddu_pkg::DefNumDisplays,
  parameter int unsigned DigitsPerDisplay = cddu_pkg::DefDigitsPerDisplay,
  localparam int unsigned SlotW = (NumDisplays > 1) ? $clog2(NumDisplays) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_take_o,
  input  logic [SlotW-1:0] q_slot_i,
  input  logic [DigitsPerDisplay-1:0][cddu_pkg::CodeW-1:0] q_codes_i,
  output logic cmd_push_o,
  input  logic cmd_full_i,
  output cddu_pkg::cmd_t cmd_o
);

  localparam int unsigned PosW  = (DigitsPerDisplay > 1) ? $clog2(DigitsPerDisplay) : 1;
  localparam int unsigned AddrW = SlotW + PosW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned CodeW = cddu_pkg::CodeW;

  // Issue stage: walks the digit positions of the current update.
  logic                                       a_vld_q, a_vld_d;
  logic [SlotW-1:0]                           a_slot_q;
  logic [DigitsPerDisplay-1:0][CodeW-1:0]     a_codes_q;
  logic [PosW-1:0]                            a_pos_q, a_pos_d;

  // Compare stage: shadow copy arrives from the RAM.
  logic             b_vld_q;
  logic [SlotW-1:0] b_slot_q;
  logic [PosW-1:0]  b_pos_q;
  logic [CodeW-1:0] b_code_q;
  logic             b_end_q;
  logic             byp_q;
  logic [CodeW-1:0] byp_data_q;
  logic             hit_vld_q;

  logic [Depth-1:0] written_q;

  logic             pend_vld_q, pend_vld_d;
  cddu_pkg::cmd_t   pend_q, pend_d;
  logic             flush_q, flush_d;

  logic             step, a_last, load, re, we, changed;
  logic [AddrW-1:0] raddr, waddr;
  logic [CodeW-1:0] rdata, shadow;
  cddu_pkg::cmd_t   new_cmd;

  assign step   = !cmd_full_i && !flush_q;
  assign a_last = a_pos_q == PosW'(DigitsPerDisplay - 1);
  assign load   = q_valid_i && (!a_vld_q || (step && a_last));
  assign q_take_o = load;

  assign re    = step && a_vld_q;
  assign raddr = {a_slot_q, a_pos_q};
  assign waddr = {b_slot_q, b_pos_q};

  assign shadow  = byp_q ? byp_data_q : (hit_vld_q ? rdata : cddu_pkg::BlankCode);
  assign changed = b_vld_q && (b_code_q != shadow);
  assign we      = step && changed;

  cddu_ram #(
    .Width(CodeW),
    .Depth(Depth)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(b_code_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    a_vld_d = a_vld_q;
    a_pos_d = a_pos_q;
    if (load) begin
      a_vld_d = 1'b1;
      a_pos_d = '0;
    end else if (step && a_vld_q) begin
      if (a_last) begin
        a_vld_d = 1'b0;
      end else begin
        a_pos_d = a_pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    new_cmd.frame_slot     = cddu_pkg::FrameSlotW'(b_slot_q);
    new_cmd.digit_register = cddu_pkg::TopRegister - cddu_pkg::DigitRegW'(b_pos_q);
    new_cmd.segment_code   = b_code_q;
    new_cmd.last           = 1'b0;

    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    flush_d    = flush_q;
    cmd_push_o = 1'b0;
    cmd_o      = pend_q;

    if (flush_q) begin
      if (!cmd_full_i) begin
        cmd_push_o  = 1'b1;
        cmd_o.last  = 1'b1;
        pend_vld_d  = 1'b0;
        flush_d     = 1'b0;
      end
    end else if (step && b_vld_q) begin
      if (changed) begin
        if (pend_vld_q) begin
          cmd_push_o = 1'b1;
          pend_d     = new_cmd;
          flush_d    = b_end_q;
        end else if (b_end_q) begin
          cmd_push_o = 1'b1;
          cmd_o      = new_cmd;
          cmd_o.last = 1'b1;
        end else begin
          pend_vld_d = 1'b1;
          pend_d     = new_cmd;
        end
      end else if (b_end_q && pend_vld_q) begin
        cmd_push_o = 1'b1;
        cmd_o.last = 1'b1;
        pend_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q    <= 1'b0;
      a_pos_q    <= '0;
      b_vld_q    <= 1'b0;
      written_q  <= '0;
      pend_vld_q <= 1'b0;
      flush_q    <= 1'b0;
    end else begin
      a_vld_q    <= a_vld_d;
      a_pos_q    <= a_pos_d;
      pend_vld_q <= pend_vld_d;
      flush_q    <= flush_d;
      if (step) begin
        b_vld_q <= a_vld_q;
      end
      if (we) begin
        written_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (load) begin
      a_slot_q  <= q_slot_i;
      a_codes_q <= q_codes_i;
    end
    if (re) begin
      b_slot_q   <= a_slot_q;
      b_pos_q    <= a_pos_q;
      b_code_q   <= a_codes_q[a_pos_q];
      b_end_q    <= a_last;
      // A write to the entry being read in the same cycle is forwarded.
      byp_q      <= we && (waddr == raddr);
      byp_data_q <= b_code_q;
      hit_vld_q  <= written_q[raddr];
    end
  end

endmodule

/* hdl/cddu_cmd_fifo.sv */
module cddu_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cddu_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop,
  output logic           empty,
  output cddu_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = cddu_pkg::OutQueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cddu_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            enq, deq;

  assign full_o = count_q == CntW'(Depth);
  assign empty  = count_q == '0;
  assign enq    = push_i && !full_o;
  assign deq    = pop && !empty;
  assign cmd_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(enq) - CntW'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/chained_digit_display_updater.sv */
// The back end compares one digit per cycle through the shadow RAM read port, taking the next
// update while it reads the final digit of the current one; it waits while the command queue
// is full and while it flushes a held command when a final digit changes after an earlier one.
// A command is released when the next change of its update, or its end, is compared.
// Reset: asynchronous, active low; queues empty, and unwritten shadow digits read as 0x0f.
module chained_digit_display_updater #(
  parameter int unsigned NumDisplays      = cddu_pkg::DefNumDisplays,
  parameter int unsigned DigitsPerDisplay = cddu_pkg::DefDigitsPerDisplay
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  // Update beats: one display index and eight digit codes.
  input  logic       push,
  output logic       full,
  input  logic [1:0] display_index_i,
  input  logic [7:0] digit_code_0_i,
  input  logic [7:0] digit_code_1_i,
  input  logic [7:0] digit_code_2_i,
  input  logic [7:0] digit_code_3_i,
  input  logic [7:0] digit_code_4_i,
  input  logic [7:0] digit_code_5_i,
  input  logic [7:0] digit_code_6_i,
  input  logic [7:0] digit_code_7_i,

  // Command beats toward the chained drivers.
  output logic       empty,
  input  logic       pop,
  output logic [1:0] frame_slot_o,
  output logic [3:0] digit_register_o,
  output logic [7:0] segment_code_o,
  output logic       last_o
);

  localparam int unsigned SlotW = (NumDisplays > 1) ? $clog2(NumDisplays) : 1;

  logic [cddu_pkg::MaxDigits-1:0][cddu_pkg::CodeW-1:0] digit_codes;
  logic                                                 q_valid, q_take;
  logic [SlotW-1:0]                                     q_slot;
  logic [DigitsPerDisplay-1:0][cddu_pkg::CodeW-1:0]     q_codes;
  logic                                                 cmd_push, cmd_full;
  cddu_pkg::cmd_t                                       cmd_in, cmd_out;

  assign digit_codes = {digit_code_7_i, digit_code_6_i, digit_code_5_i, digit_code_4_i,
                        digit_code_3_i, digit_code_2_i, digit_code_1_i, digit_code_0_i};

  // The front end takes update beats, drops those addressing a display beyond the chain, turns
  // the display index into a frame slot and parks the update in a two-entry queue.
  cddu_front #(
    .NumDisplays     (NumDisplays),
    .DigitsPerDisplay(DigitsPerDisplay)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .display_index_i(display_index_i),
    .digit_codes_i  (digit_codes),
    .q_valid_o      (q_valid),
    .q_take_i       (q_take),
    .q_slot_o       (q_slot),
    .q_codes_o      (q_codes)
  );

  // The back end walks the digits of one update, compares each with its shadow copy, writes the
  // changed ones back and holds each command back so that the last one can be marked.
  cddu_back #(
    .NumDisplays     (NumDisplays),
    .DigitsPerDisplay(DigitsPerDisplay)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_take_o  (q_take),
    .q_slot_i  (q_slot),
    .q_codes_i (q_codes),
    .cmd_push_o(cmd_push),
    .cmd_full_i(cmd_full),
    .cmd_o     (cmd_in)
  );

  // Commands wait here until the consumer pops them; the back end stalls when it is full.
  cddu_cmd_fifo u_cmd_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(cmd_push),
    .cmd_i (cmd_in),
    .full_o(cmd_full),
    .pop   (pop),
    .empty (empty),
    .cmd_o (cmd_out)
  );

  assign frame_slot_o     = cmd_out.frame_slot;
  assign digit_register_o = cmd_out.digit_register;
  assign segment_code_o   = cmd_out.segment_code;
  assign last_o           = cmd_out.last;

endmodule
